@@ hw/rtl/smo_pkg.sv @@
// Shared types, microcode table and arithmetic helpers for the sliding-mode EMF observer.
package smo_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_CURRENT_DECAY  = 3'd0;
    localparam logic [2:0] REG_INPUT_GAIN     = 3'd1;
    localparam logic [2:0] REG_SLIDE_GAIN     = 3'd2;
    localparam logic [2:0] REG_BOUNDARY_RECIP = 3'd3;
    localparam logic [2:0] REG_LPF_NEW_WEIGHT = 3'd4;
    localparam logic [2:0] REG_LPF_OLD_WEIGHT = 3'd5;
    localparam logic [2:0] REG_DIRECTION_BAND = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [15:0] BOUNDARY_RECIP_RESET = 16'd512;
    localparam logic [14:0] DIRECTION_BAND_RESET = 15'd50;

    // Accumulator width and saturation limits.
    localparam int ACC_W = 40;
    localparam logic signed [ACC_W-1:0] LIM_HI16 = 40'sd32767;
    localparam logic signed [ACC_W-1:0] LIM_HI17 = 40'sd32768;
    localparam logic signed [ACC_W-1:0] LIM_LO   = -40'sd32768;
    localparam logic signed [ACC_W-1:0] RND_16   = 40'sd32768;
    localparam logic signed [ACC_W-1:0] RND_15   = 40'sd16384;
    localparam logic signed [ACC_W-1:0] RND_8    = 40'sd128;

    // Multiplier operand A sources.
    typedef enum logic [2:0] {
        A_EST   = 3'd0,
        A_VDIFF = 3'd1,
        A_ERR   = 3'd2,
        A_SCL   = 3'd3,
        A_EMF   = 3'd4,
        A_SW    = 3'd5
    } a_sel_t;

    // Multiplier operand B sources.
    typedef enum logic [2:0] {
        B_DECAY = 3'd0,
        B_GAIN  = 3'd1,
        B_RECIP = 3'd2,
        B_SLIDE = 3'd3,
        B_OLDW  = 3'd4,
        B_NEWW  = 3'd5
    } b_sel_t;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    // Writeback target; the target also fixes the rounding shift and limit.
    typedef enum logic [2:0] {
        WB_NONE = 3'd0,
        WB_EST  = 3'd1,
        WB_SCL  = 3'd2,
        WB_SW   = 3'd3,
        WB_EMF  = 3'd4
    } wb_dst_t;

    // Program flow after a step.
    typedef enum logic [1:0] {
        JMP_NEXT = 2'd0,
        JMP_AXIS = 2'd1,
        JMP_END  = 2'd2
    } jmp_t;

    // One control word.
    typedef struct packed {
        logic    mul_en;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        logic    acc_sh4;
        wb_dst_t wb_dst;
        jmp_t    jmp;
    } ucode_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic   en;
        logic   last;
        logic   axis;
        ucode_t uc;
    } seq_ctrl_t;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] current_decay;
        logic [15:0] input_gain;
        logic [14:0] slide_gain;
        logic [15:0] boundary_recip;
        logic [15:0] lpf_new_weight;
        logic [15:0] lpf_old_weight;
        logic [14:0] direction_band;
    } cfg_t;

    // Result of one sample.
    typedef struct packed {
        logic signed [15:0] emf_alpha;
        logic signed [15:0] emf_beta;
        logic               reverse_dir;
    } res_t;

    localparam int PC_W = 4;

    // Microcode program: steps 0 to 13 run once per axis, step 14 closes the sample.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{mul_en: 1'b0, a_sel: A_EST, b_sel: B_DECAY, acc_op: ACC_HOLD,
              acc_sh4: 1'b0, wb_dst: WB_NONE, jmp: JMP_NEXT};
        case (pc)
            4'd0:
            begin
                w.mul_en = 1'b1; w.a_sel = A_EST; w.b_sel = B_DECAY;
            end
            4'd1:
            begin
                w.acc_op = ACC_LOAD;
                w.mul_en = 1'b1; w.a_sel = A_VDIFF; w.b_sel = B_GAIN;
            end
            4'd2:
            begin
                w.acc_op = ACC_ADD; w.acc_sh4 = 1'b1;
            end
            4'd3:
            begin
                w.wb_dst = WB_EST;
            end
            4'd4:
            begin
                w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_RECIP;
            end
            4'd5:
            begin
                w.acc_op = ACC_LOAD;
            end
            4'd6:
            begin
                w.wb_dst = WB_SCL;
            end
            4'd7:
            begin
                w.mul_en = 1'b1; w.a_sel = A_SCL; w.b_sel = B_SLIDE;
            end
            4'd8:
            begin
                w.acc_op = ACC_LOAD;
            end
            4'd9:
            begin
                w.wb_dst = WB_SW;
            end
            4'd10:
            begin
                w.mul_en = 1'b1; w.a_sel = A_EMF; w.b_sel = B_OLDW;
            end
            4'd11:
            begin
                w.acc_op = ACC_LOAD;
                w.mul_en = 1'b1; w.a_sel = A_SW; w.b_sel = B_NEWW;
            end
            4'd12:
            begin
                w.acc_op = ACC_ADD;
            end
            4'd13:
            begin
                w.wb_dst = WB_EMF; w.jmp = JMP_AXIS;
            end
            4'd14:
            begin
                w.jmp = JMP_END;
            end
            default:
            begin
                w.jmp = JMP_END;
            end
        endcase
        return w;
    endfunction

    // Negate with saturation of the most negative value.
    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] x);
        logic signed [15:0] r;
        if (x == -16'sd32768)
            r = 16'sd32767;
        else
            r = -x;
        return r;
    endfunction

endpackage

@@ hw/rtl/sliding_mode_emf_observer.sv @@
// Top level of the sliding-mode back-EMF observer: handshakes, configuration and result register.
//
//  Channel   Handshake                   Payload
//  sample    sample_valid / sample_stall meas_i_alpha/beta, volt_alpha/beta, speed_*
//  result    result_valid / result_stall emf_alpha, emf_beta, reverse_dir
//  config    cfg_valid / cfg_ready       cfg_index (3b), cfg_data (16b)
//
// The microcode runs 14 steps per axis through one shared 18x18 multiplier and accumulator,
// plus one closing step, and the input stalls until the program is idle again.
// A new sample is accepted once the program is idle, even while a result waits.
// The closing step holds while the result register is full and stalled.
// Reset clears the observer state and loads the register defaults; cfg_ready is always high.
module sliding_mode_emf_observer
    import smo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [15:0] meas_i_alpha,
    input  logic signed [15:0] meas_i_beta,
    input  logic signed [15:0] volt_alpha,
    input  logic signed [15:0] volt_beta,
    input  logic signed [15:0] speed_command,
    input  logic signed [15:0] speed_feedback,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] emf_alpha,
    output logic signed [15:0] emf_beta,
    output logic               reverse_dir,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    cfg_t      cfg_reg;
    seq_ctrl_t ctrl;
    res_t      res;
    res_t      res_reg;
    logic      res_valid_reg;
    logic      busy;
    logic      sample_take;
    logic      out_free;

    assign sample_stall = busy;
    assign sample_take  = sample_valid && !busy;
    assign out_free     = !res_valid_reg || !result_stall;
    assign cfg_ready    = 1'b1;

    assign result_valid = res_valid_reg;
    assign emf_alpha    = res_reg.emf_alpha;
    assign emf_beta     = res_reg.emf_beta;
    assign reverse_dir  = res_reg.reverse_dir;

    smo_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sample_take),
        .out_free (out_free),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    smo_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg_reg),
        .load           (sample_take),
        .meas_i_alpha   (meas_i_alpha),
        .meas_i_beta    (meas_i_beta),
        .volt_alpha     (volt_alpha),
        .volt_beta      (volt_beta),
        .speed_command  (speed_command),
        .speed_feedback (speed_feedback),
        .res            (res)
    );

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_decay  <= '0;
            cfg_reg.input_gain     <= '0;
            cfg_reg.slide_gain     <= '0;
            cfg_reg.boundary_recip <= BOUNDARY_RECIP_RESET;
            cfg_reg.lpf_new_weight <= '0;
            cfg_reg.lpf_old_weight <= '0;
            cfg_reg.direction_band <= DIRECTION_BAND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CURRENT_DECAY:  cfg_reg.current_decay  <= cfg_data;
                REG_INPUT_GAIN:     cfg_reg.input_gain     <= cfg_data;
                REG_SLIDE_GAIN:     cfg_reg.slide_gain     <= cfg_data[14:0];
                REG_BOUNDARY_RECIP: cfg_reg.boundary_recip <= cfg_data;
                REG_LPF_NEW_WEIGHT: cfg_reg.lpf_new_weight <= cfg_data;
                REG_LPF_OLD_WEIGHT: cfg_reg.lpf_old_weight <= cfg_data;
                REG_DIRECTION_BAND: cfg_reg.direction_band <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    // Result valid flag: set by the closing step, cleared when the transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (ctrl.last)
            res_valid_reg <= 1'b1;
        else if (!result_stall)
            res_valid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.last)
            res_reg <= res;
    end

endmodule

@@ hw/rtl/smo_sequencer.sv @@
// Microcode sequencer: step counter, axis bit and control word fetch.
module smo_sequencer
    import smo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      out_free,
    output logic      busy,
    output seq_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            axis_reg, axis_next;
    ucode_t          uc;
    logic            advance;

    // Fetch the control word; the closing step waits for a free result slot.
    always_comb
    begin
        uc      = ucode_rom(pc_reg);
        advance = (state_reg == ST_RUN) && ((uc.jmp != JMP_END) || out_free);
        ctrl.en   = advance;
        ctrl.last = advance && (uc.jmp == JMP_END);
        ctrl.axis = axis_reg;
        ctrl.uc   = uc;
        busy      = (state_reg != ST_IDLE);
    end

    // Next step and branch decision.
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                    axis_next  = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    case (uc.jmp)
                        JMP_AXIS:
                        begin
                            if (!axis_reg)
                            begin
                                axis_next = 1'b1;
                                pc_next   = '0;
                            end
                            else
                            begin
                                pc_next = pc_reg + PC_W'(1);
                            end
                        end
                        JMP_END:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            pc_next = pc_reg + PC_W'(1);
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

@@ hw/rtl/smo_datapath.sv @@
// Observer datapath: shared multiplier, accumulator, rounding writeback and direction logic.
module smo_datapath
    import smo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  seq_ctrl_t          ctrl,
    input  cfg_t               cfg,
    input  logic               load,
    input  logic signed [15:0] meas_i_alpha,
    input  logic signed [15:0] meas_i_beta,
    input  logic signed [15:0] volt_alpha,
    input  logic signed [15:0] volt_beta,
    input  logic signed [15:0] speed_command,
    input  logic signed [15:0] speed_feedback,
    output res_t               res
);

    // Sample latches.
    logic signed [15:0] meas_reg [2];
    logic signed [15:0] volt_reg [2];
    logic signed [15:0] cmd_reg;
    logic signed [15:0] fb_reg;

    // Observer state: one entry per axis, plus the direction flag.
    logic signed [15:0] est_reg [2];
    logic signed [15:0] sw_reg  [2];
    logic signed [15:0] emf_reg [2];
    logic               dir_reg, dir_next;

    // Scratch registers.
    logic signed [16:0]      scl_reg;
    logic signed [35:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic signed [17:0]      a_op, b_op;
    logic signed [16:0]      vdiff, err;
    logic signed [ACC_W-1:0] prod_ext, rnd, lim_hi;
    logic signed [16:0]      wb_val;
    logic signed [16:0]      fb17, band17;

    // Operand selection for the multiplier.
    always_comb
    begin
        vdiff = {volt_reg[ctrl.axis][15], volt_reg[ctrl.axis]}
              - {sw_reg[ctrl.axis][15], sw_reg[ctrl.axis]};
        err   = {est_reg[ctrl.axis][15], est_reg[ctrl.axis]}
              - {meas_reg[ctrl.axis][15], meas_reg[ctrl.axis]};
        case (ctrl.uc.a_sel)
            A_EST:   a_op = {{2{est_reg[ctrl.axis][15]}}, est_reg[ctrl.axis]};
            A_VDIFF: a_op = {vdiff[16], vdiff};
            A_ERR:   a_op = {err[16], err};
            A_SCL:   a_op = {scl_reg[16], scl_reg};
            A_EMF:   a_op = {{2{emf_reg[ctrl.axis][15]}}, emf_reg[ctrl.axis]};
            A_SW:    a_op = {{2{sw_reg[ctrl.axis][15]}}, sw_reg[ctrl.axis]};
            default: a_op = '0;
        endcase
        case (ctrl.uc.b_sel)
            B_DECAY: b_op = {2'b00, cfg.current_decay};
            B_GAIN:  b_op = {2'b00, cfg.input_gain};
            B_RECIP: b_op = {2'b00, cfg.boundary_recip};
            B_SLIDE: b_op = {3'b000, cfg.slide_gain};
            B_OLDW:  b_op = {2'b00, cfg.lpf_old_weight};
            B_NEWW:  b_op = {2'b00, cfg.lpf_new_weight};
            default: b_op = '0;
        endcase
    end

    // Accumulate the registered product, optionally scaled by 16.
    always_comb
    begin
        prod_ext = {{(ACC_W-36){prod_reg[35]}}, prod_reg};
        if (ctrl.uc.acc_sh4)
            prod_ext = prod_ext <<< 4;
        case (ctrl.uc.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // Round to nearest with ties upward, then saturate for the target.
    always_comb
    begin
        lim_hi = LIM_HI16;
        case (ctrl.uc.wb_dst)
            WB_SCL:
            begin
                rnd    = (acc_reg + RND_8) >>> 8;
                lim_hi = LIM_HI17;
            end
            WB_SW:   rnd = (acc_reg + RND_15) >>> 15;
            default: rnd = (acc_reg + RND_16) >>> 16;
        endcase
        if (rnd > lim_hi)
            wb_val = lim_hi[16:0];
        else if (rnd < LIM_LO)
            wb_val = LIM_LO[16:0];
        else
            wb_val = rnd[16:0];
    end

    // Direction hysteresis and direction-signed result.
    always_comb
    begin
        fb17   = {fb_reg[15], fb_reg};
        band17 = {2'b00, cfg.direction_band};
        dir_next = dir_reg;
        if (!cmd_reg[15])
        begin
            if (fb17 >= -band17)
                dir_next = 1'b0;
        end
        else
        begin
            if (fb17 <= band17)
                dir_next = 1'b1;
        end
        res.reverse_dir = dir_next;
        res.emf_alpha   = dir_next ? neg_sat16(emf_reg[0]) : emf_reg[0];
        res.emf_beta    = dir_next ? neg_sat16(emf_reg[1]) : emf_reg[1];
    end

    // Sample latches and scratch registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meas_reg[0] <= meas_i_alpha;
            meas_reg[1] <= meas_i_beta;
            volt_reg[0] <= volt_alpha;
            volt_reg[1] <= volt_beta;
            cmd_reg     <= speed_command;
            fb_reg      <= speed_feedback;
        end
        if (ctrl.en && ctrl.uc.mul_en)
            prod_reg <= a_op * b_op;
        if (ctrl.en)
            acc_reg <= acc_next;
        if (ctrl.en && (ctrl.uc.wb_dst == WB_SCL))
            scl_reg <= wb_val;
    end

    // Observer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg[0] <= '0;
            est_reg[1] <= '0;
            sw_reg[0]  <= '0;
            sw_reg[1]  <= '0;
            emf_reg[0] <= '0;
            emf_reg[1] <= '0;
            dir_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.en)
            begin
                case (ctrl.uc.wb_dst)
                    WB_EST:  est_reg[ctrl.axis] <= wb_val[15:0];
                    WB_SW:   sw_reg[ctrl.axis]  <= wb_val[15:0];
                    WB_EMF:  emf_reg[ctrl.axis] <= wb_val[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (ctrl.last)
                dir_reg <= dir_next;
        end
    end

endmodule

@@ tb/tb_sliding_mode_emf_observer.sv @@
// Self-checking testbench for the sliding-mode back-EMF observer.
`timescale 1ns / 1ps

module tb_sliding_mode_emf_observer
    import smo_pkg::*;
();

    localparam int CLK_HALF = 2;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 60;

    // Index past the last register; writes to it must be ignored.
    localparam logic [2:0] REG_OUT_OF_RANGE = 3'd7;

    // Register settings used by the directed table.
    typedef enum logic [1:0] {
        SET_RESET       = 2'd0,
        SET_EXTREME     = 2'd1,
        SET_NO_BOUNDARY = 2'd2
    } dir_set_t;

    // One sample as it crosses the input channel.
    typedef struct packed {
        logic signed [15:0] meas_a;
        logic signed [15:0] meas_b;
        logic signed [15:0] volt_a;
        logic signed [15:0] volt_b;
        logic signed [15:0] cmd;
        logic signed [15:0] fb;
    } obs_sample_t;

    // One row of the directed table; want is used only when typed is set.
    typedef struct packed {
        obs_sample_t smp;
        dir_set_t    setting;
        logic        typed;
        res_t        want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 21;

    // Default registers give zero EMF, so only the direction hysteresis is visible.
    // The extreme setting drives estimate and EMF saturation and the negation of
    // the most negative EMF; the last setting has a zero boundary reciprocal.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd1, 16'sd51},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd50},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd32768, -16'sd32768},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{'{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd0, -16'sd51},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{'{16'sd12345, -16'sd12345, 16'sd0, 16'sd0, 16'sd32767, -16'sd50},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd5, -16'sd32768},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b1}},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767},
          SET_RESET, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd1, 16'sd0},
          SET_EXTREME, 1'b0, '0},
        '{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd1, 16'sd0},
          SET_EXTREME, 1'b0, '0},
        '{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd1, 16'sd0},
          SET_EXTREME, 1'b0, '0},
        '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0},
          SET_EXTREME, 1'b0, '0},
        '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0},
          SET_EXTREME, 1'b0, '0},
        '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0},
          SET_EXTREME, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767},
          SET_EXTREME, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 16'sd0, -16'sd32768},
          SET_EXTREME, 1'b0, '0},
        '{'{16'sd1000, -16'sd1000, 16'sd20000, -16'sd20000, 16'sd0, 16'sd0},
          SET_NO_BOUNDARY, 1'b0, '0},
        '{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd1, 16'sd0},
          SET_NO_BOUNDARY, 1'b0, '0},
        '{'{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, -16'sd1},
          SET_NO_BOUNDARY, 1'b0, '0},
        '{'{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0},
          SET_NO_BOUNDARY, 1'b0, '0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               sample_valid = 1'b0;
    logic               sample_stall;
    logic signed [15:0] meas_i_alpha = '0;
    logic signed [15:0] meas_i_beta = '0;
    logic signed [15:0] volt_alpha = '0;
    logic signed [15:0] volt_beta = '0;
    logic signed [15:0] speed_command = '0;
    logic signed [15:0] speed_feedback = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [15:0] emf_alpha;
    logic signed [15:0] emf_beta;
    logic               reverse_dir;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = REG_CURRENT_DECAY;
    logic [15:0]        cfg_data = '0;

    // Observer state and register copy kept by the testbench.
    cfg_t               obs_cfg;
    logic signed [15:0] obs_est [2];
    logic signed [15:0] obs_sw [2];
    logic signed [15:0] obs_emf [2];
    logic               obs_reverse;

    res_t pending_emf [$];
    int   mismatches = 0;

    // Receiver pacing, set by the main sequence.
    int   stall_pct = 25;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   run_left = 0;
    logic run_stall = 1'b0;
    int   burst_left = 0;
    res_t want_now;

    sliding_mode_emf_observer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .meas_i_alpha   (meas_i_alpha),
        .meas_i_beta    (meas_i_beta),
        .volt_alpha     (volt_alpha),
        .volt_beta      (volt_beta),
        .speed_command  (speed_command),
        .speed_feedback (speed_feedback),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .emf_alpha      (emf_alpha),
        .emf_beta       (emf_beta),
        .reverse_dir    (reverse_dir),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Saturate to the signed 16-bit range.
    function automatic logic signed [15:0] clip16(input longint x);
        if (x > 32767)
            return 16'sd32767;
        if (x < -32768)
            return -16'sd32768;
        return 16'(x);
    endfunction

    // Shift right by k, rounding to nearest with ties toward plus infinity.
    function automatic longint round_q(input longint x, input int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    // Estimate, boundary-layer switch and EMF filter for one axis.
    function automatic void step_axis(input logic signed [15:0] meas,
                                      input logic signed [15:0] volt,
                                      inout logic signed [15:0] est,
                                      inout logic signed [15:0] sw,
                                      inout logic signed [15:0] emf);
        longint acc;
        longint scaled;
        acc = longint'(est) * longint'(obs_cfg.current_decay)
            + (longint'(volt) - longint'(sw)) * longint'(obs_cfg.input_gain) * 16;
        est = clip16(round_q(acc, 16));
        scaled = round_q((longint'(est) - longint'(meas))
                         * longint'(obs_cfg.boundary_recip), 8);
        // The clamped error may reach +1.0, one step above the 16-bit range.
        if (scaled > 32768)
            scaled = 32768;
        else if (scaled < -32768)
            scaled = -32768;
        sw = clip16(round_q(scaled * longint'(obs_cfg.slide_gain), 15));
        acc = longint'(emf) * longint'(obs_cfg.lpf_old_weight)
            + longint'(sw) * longint'(obs_cfg.lpf_new_weight);
        emf = clip16(round_q(acc, 16));
    endfunction

    // Advance the observer by one sample and return the output it produces.
    function automatic res_t advance_observer(input obs_sample_t s);
        res_t   r;
        longint band;
        longint fb;
        band = longint'(obs_cfg.direction_band);
        fb = longint'($signed(s.fb));
        step_axis(s.meas_a, s.volt_a, obs_est[0], obs_sw[0], obs_emf[0]);
        step_axis(s.meas_b, s.volt_b, obs_est[1], obs_sw[1], obs_emf[1]);
        // Direction changes only once the speed has left the hysteresis band.
        if (!s.cmd[15])
        begin
            if (fb >= -band)
                obs_reverse = 1'b0;
        end
        else if (fb <= band)
        begin
            obs_reverse = 1'b1;
        end
        r.emf_alpha = obs_reverse ? clip16(-longint'(obs_emf[0])) : obs_emf[0];
        r.emf_beta = obs_reverse ? clip16(-longint'(obs_emf[1])) : obs_emf[1];
        r.reverse_dir = obs_reverse;
        return r;
    endfunction

    // Random sample: mostly near the estimate so the error stays in the boundary layer.
    function automatic obs_sample_t random_sample();
        obs_sample_t s;
        longint band;
        band = longint'(obs_cfg.direction_band);
        s.meas_a = 16'($urandom);
        s.meas_b = 16'($urandom);
        s.volt_a = 16'($urandom);
        s.volt_b = 16'($urandom);
        s.cmd = 16'($urandom);
        s.fb = 16'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            s.meas_a = clip16(longint'(obs_est[0]) + longint'($urandom_range(0, 4096)) - 2048);
            s.meas_b = clip16(longint'(obs_est[1]) + longint'($urandom_range(0, 4096)) - 2048);
            if ($urandom_range(0, 1) == 1)
            begin
                s.volt_a = clip16(longint'(obs_sw[0]) + longint'($urandom_range(0, 8192)) - 4096);
                s.volt_b = clip16(longint'(obs_sw[1]) + longint'($urandom_range(0, 8192)) - 4096);
            end
            s.cmd = clip16(longint'($urandom_range(0, 6000)) - 3000);
            s.fb = clip16(($urandom_range(0, 1) == 1 ? band : -band)
                          + longint'($urandom_range(0, 8)) - 4);
        end
        return s;
    endfunction

    // Register settings for one random phase; the first two are the extremes.
    function automatic cfg_t random_settings(input int phase);
        cfg_t c;
        if (phase == 0)
        begin
            c = '1;
        end
        else if (phase == 1)
        begin
            c = '0;
        end
        else if (phase % 2 == 1)
        begin
            c.current_decay = 16'($urandom);
            c.input_gain = 16'($urandom);
            c.slide_gain = 15'($urandom);
            c.boundary_recip = 16'($urandom);
            c.lpf_new_weight = 16'($urandom);
            c.lpf_old_weight = 16'($urandom);
            c.direction_band = 15'($urandom);
        end
        else
        begin
            c.current_decay = 16'($urandom_range(55000, 65535));
            c.input_gain = 16'($urandom_range(0, 8192));
            c.slide_gain = 15'($urandom_range(1000, 32767));
            c.boundary_recip = 16'($urandom_range(1, 1 << $urandom_range(0, 15)));
            c.lpf_new_weight = 16'($urandom_range(100, 20000));
            c.lpf_old_weight = 16'(65536 - c.lpf_new_weight - $urandom_range(0, 64));
            c.direction_band = 15'($urandom_range(0, 500));
        end
        return c;
    endfunction

    task automatic flag_error(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    // One register write transaction; the shadow copy keeps only the register's width.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CURRENT_DECAY:  obs_cfg.current_decay = data;
            REG_INPUT_GAIN:     obs_cfg.input_gain = data;
            REG_SLIDE_GAIN:     obs_cfg.slide_gain = data[14:0];
            REG_BOUNDARY_RECIP: obs_cfg.boundary_recip = data;
            REG_LPF_NEW_WEIGHT: obs_cfg.lpf_new_weight = data;
            REG_LPF_OLD_WEIGHT: obs_cfg.lpf_old_weight = data;
            REG_DIRECTION_BAND: obs_cfg.direction_band = data[14:0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input cfg_t c);
        write_reg(REG_CURRENT_DECAY, c.current_decay);
        write_reg(REG_INPUT_GAIN, c.input_gain);
        write_reg(REG_SLIDE_GAIN, {1'b0, c.slide_gain});
        write_reg(REG_BOUNDARY_RECIP, c.boundary_recip);
        write_reg(REG_LPF_NEW_WEIGHT, c.lpf_new_weight);
        write_reg(REG_LPF_OLD_WEIGHT, c.lpf_old_weight);
        write_reg(REG_DIRECTION_BAND, {1'b0, c.direction_band});
        cfg_valid <= 1'b0;
    endtask

    task automatic load_directed_setting(input dir_set_t which);
        case (which)
            SET_EXTREME:
            begin
                write_settings('1);
            end
            SET_NO_BOUNDARY:
            begin
                // The top bit of the 15-bit registers is set here and must be dropped.
                write_reg(REG_CURRENT_DECAY, 16'd32768);
                write_reg(REG_INPUT_GAIN, 16'd4096);
                write_reg(REG_SLIDE_GAIN, 16'hFFFF);
                write_reg(REG_BOUNDARY_RECIP, 16'd0);
                write_reg(REG_LPF_NEW_WEIGHT, 16'd16384);
                write_reg(REG_LPF_OLD_WEIGHT, 16'd49152);
                write_reg(REG_DIRECTION_BAND, 16'h8000);
                write_reg(REG_OUT_OF_RANGE, 16'hFFFF);
                cfg_valid <= 1'b0;
            end
            default:
            begin
                write_settings('{current_decay: '0, input_gain: '0, slide_gain: '0,
                                 boundary_recip: BOUNDARY_RECIP_RESET,
                                 lpf_new_weight: '0, lpf_old_weight: '0,
                                 direction_band: DIRECTION_BAND_RESET});
            end
        endcase
    endtask

    // Offer one sample and wait for its transaction, then queue what it should produce.
    task automatic send_sample(input obs_sample_t s, input logic typed, input res_t want);
        res_t predicted;
        sample_valid <= 1'b1;
        meas_i_alpha <= s.meas_a;
        meas_i_beta <= s.meas_b;
        volt_alpha <= s.volt_a;
        volt_beta <= s.volt_b;
        speed_command <= s.cmd;
        speed_feedback <= s.fb;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predicted = advance_observer(s);
        pending_emf.push_back(typed ? want : predicted);
    endtask

    // Stop offering samples and wait until every result has come back.
    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_emf.size() != 0)
            @(posedge clk);
    endtask

    // Sender bursts: a random run of back-to-back samples, with a random gap before each run when max_gap is nonzero.
    task automatic pace_sender(input int max_gap);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if (max_gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat ($urandom_range(1, max_gap))
                    @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Result side: check each transaction, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_emf.size() == 0)
            begin
                flag_error($sformatf("result with nothing pending: %0d %0d %0b",
                                     emf_alpha, emf_beta, reverse_dir));
            end
            else
            begin
                want_now = pending_emf.pop_front();
                if (emf_alpha !== want_now.emf_alpha)
                    flag_error($sformatf("emf_alpha: got %0d, expected %0d",
                                         emf_alpha, want_now.emf_alpha));
                if (emf_beta !== want_now.emf_beta)
                    flag_error($sformatf("emf_beta: got %0d, expected %0d",
                                         emf_beta, want_now.emf_beta));
                if (reverse_dir !== want_now.reverse_dir)
                    flag_error($sformatf("reverse_dir: got %0b, expected %0b",
                                         reverse_dir, want_now.reverse_dir));
            end
        end
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (run_left == 0)
            begin
                run_stall = ($urandom_range(0, 99) < stall_pct);
                run_left = $urandom_range(1, 8);
            end
            run_left--;
            result_stall <= run_stall;
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases.
    initial
    begin
        dir_set_t    cur_set;
        obs_sample_t smp;
        cfg_t        settings;

        obs_cfg = '{current_decay: '0, input_gain: '0, slide_gain: '0,
                    boundary_recip: BOUNDARY_RECIP_RESET, lpf_new_weight: '0,
                    lpf_old_weight: '0, direction_band: DIRECTION_BAND_RESET};
        obs_est = '{default: '0};
        obs_sw = '{default: '0};
        obs_emf = '{default: '0};
        obs_reverse = 1'b0;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; registers change only once the block has drained.
        cur_set = SET_RESET;
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].setting != cur_set)
            begin
                wait_drained();
                load_directed_setting(DIRECTED[i].setting);
                cur_set = DIRECTED[i].setting;
            end
            send_sample(DIRECTED[i].smp, DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Random phases, each with its own registers and pacing.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            settings = random_settings(phase);
            write_settings(settings);
            stall_pct <= (phase % 4) * 25;
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pace_sender((phase % 3 == 0) ? 0 : 12);
                // Long receiver hold-off while samples keep coming, to back up the input.
                if (phase == 2 && n == 10)
                    hold_reqs <= hold_reqs + 1;
                // Pause the sender until every result is back.
                if (phase == 5 && n == 30)
                    wait_drained();
                smp = random_sample();
                send_sample(smp, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && pending_emf.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sliding_mode_emf_observer.f @@
hw/rtl/smo_pkg.sv
hw/rtl/smo_sequencer.sv
hw/rtl/smo_datapath.sv
hw/rtl/sliding_mode_emf_observer.sv
tb/tb_sliding_mode_emf_observer.sv
